// ===== rtl/core/fnr_pkg.sv =====
// Shared types, field widths and register codes for the float result normalizer.
// Used by float_result_normalize_round_top; has no dependencies of its own.
package fnr_pkg;

  localparam int MAG_W     = 80;  // acc:ext magnitude below the double sign
  localparam int HALF_W    = 40;
  localparam int EXP_W     = 16;
  localparam int XEXP_W    = 7;
  localparam int SHIFT_W   = 7;   // left shift count, 0 to 80
  localparam int CHUNK_W   = 16;
  localparam int IN_DATA_W = 112;
  localparam int OUT_DATA_W = 104;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_NORMALIZE_OFF     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROUNDING_OFF      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OVERFLOW_TRAP_OFF = 2'd2;

  // One word in flight, after the right shift has been settled.
  typedef struct packed {
    logic [1:0]        top2;   // double sign bits of the accumulator mantissa
    logic [MAG_W-1:0]  mag;    // acc[15:0] : acc low : ext high : ext low
    logic [EXP_W-1:0]  ex;
    logic [XEXP_W-1:0] xexp;
    logic              rnd;
    logic              left;   // word takes part in left normalization
    logic              neg;
  } item_t;

  // Leading zero count of one byte; a zero byte gives 7 and is screened by the caller.
  function automatic logic [2:0] lz8(input logic [7:0] b);
    logic [2:0] n;
    logic       found;
    n = 3'd7;
    found = 1'b0;
    for (int i = 7; i >= 0; i--) begin
      if (!found && b[i]) begin
        n = 3'(7 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

endpackage

// ===== rtl/core/float_result_normalize_round_top.sv =====
// Top level of the float result normalizer: five-stage pipeline with stream ports.
// Depends on fnr_pkg for types, widths and register codes.

// This block takes one unpacked accumulator/extension word per cycle while
// s_tready is high and returns one packed word per input, in order. It has
// five registered stages: entry and right shift, coarse leading-sign count
// in 16-bit chunks with the matching shift, fine count within a chunk, fine
// shift with exponent adjust, then the range checks, rounding and packing in
// the output register. A stall at the output backs up stage by stage, so
// bubbles are squeezed out and nothing is lost or repeated. Configuration
// writes are always taken and should be made only while no word is in flight.
module float_result_normalize_round_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // s_tdata from bit 0: acc_mant_high(18), acc_mant_low(24), acc_exponent(16),
  // ext_mant_high(16), ext_mant_low(24), ext_exponent(7), round_request(1), zero fill
  input  logic [fnr_pkg::IN_DATA_W-1:0]     s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // m_tdata from bit 0: acc_word_high(24), acc_word_low(24), ext_word_high(24),
  // ext_word_low(24), overflow_trap(1), zero fill
  output logic [fnr_pkg::OUT_DATA_W-1:0]    m_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [fnr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic                              cfg_data
);
  import fnr_pkg::*;

  logic normalize_off;
  logic rounding_off;
  logic overflow_trap_off;

  logic a_valid, b_valid, c_valid, d_valid, e_valid;
  logic a_ready, b_ready, c_ready, d_ready, e_ready;

  item_t a_item, b_item, c_item, d_item;
  logic [2:0]        b_c;
  logic [CHUNK_W-1:0] b_vtop;
  logic [HALF_W-1:0] b_lo, c_lo;
  logic [2:0]        c_c;
  logic [3:0]        c_f;
  logic              c_zero, d_zero;
  logic [95:0]       e_words;
  logic              e_trap;

  assign cfg_ready = 1'b1;

  // Each stage moves on when the one after it is empty or moving too.
  assign e_ready  = !e_valid || m_tready;
  assign d_ready  = !d_valid || e_ready;
  assign c_ready  = !c_valid || d_ready;
  assign b_ready  = !b_valid || c_ready;
  assign a_ready  = !a_valid || b_ready;
  assign s_tready = a_ready;

  // ---- entry: unpack and settle a mantissa overflow ----
  logic [17:0] in_ml;
  logic [23:0] in_mr, in_xmr;
  logic [15:0] in_xml;
  item_t       a_next;

  always_comb begin
    in_ml  = s_tdata[17:0];
    in_mr  = s_tdata[41:18];
    in_xml = s_tdata[73:58];
    in_xmr = s_tdata[97:74];
    a_next.xexp = s_tdata[104:98];
    if (in_ml[17] != in_ml[16]) begin
      // Overflow into the upper sign bit: shift the pair right one place.
      a_next.top2 = {1'b0, in_ml[17]};
      a_next.mag  = {in_ml[16:0], in_mr, in_xml, in_xmr[23:1]};
      a_next.ex   = s_tdata[57:42] + 16'd1;
      a_next.rnd  = s_tdata[105] | in_mr[0];
      a_next.left = 1'b0;
      a_next.neg  = 1'b0;
    end else begin
      a_next.top2 = in_ml[17:16];
      a_next.mag  = {in_ml[15:0], in_mr, in_xml, in_xmr};
      a_next.ex   = s_tdata[57:42];
      a_next.rnd  = s_tdata[105];
      a_next.left = !normalize_off;
      a_next.neg  = in_ml[17];
    end
  end

  // ---- coarse count: leading all-sign 16-bit chunks ----
  logic [MAG_W-1:0] a_v;
  logic [4:0]       a_z;
  logic [2:0]       b_c_next;
  item_t            b_next;
  logic [CHUNK_W-1:0] b_vtop_next;

  always_comb begin
    a_v = a_item.mag ^ {MAG_W{a_item.neg}};
    for (int i = 0; i < 5; i++) begin
      a_z[i] = (a_v[i*CHUNK_W +: CHUNK_W] == '0);
    end
    if (!a_item.left)  b_c_next = 3'd0;
    else if (!a_z[4])  b_c_next = 3'd0;
    else if (!a_z[3])  b_c_next = 3'd1;
    else if (!a_z[2])  b_c_next = 3'd2;
    else if (!a_z[1])  b_c_next = 3'd3;
    else if (!a_z[0])  b_c_next = 3'd4;
    else               b_c_next = 3'd5;
    b_next = a_item;
    case (b_c_next)
      3'd0: begin
        b_next.mag  = a_item.mag;
        b_vtop_next = a_v[79:64];
      end
      3'd1: begin
        b_next.mag  = {a_item.mag[63:0], 16'd0};
        b_vtop_next = a_v[63:48];
      end
      3'd2: begin
        b_next.mag  = {a_item.mag[47:0], 32'd0};
        b_vtop_next = a_v[47:32];
      end
      3'd3: begin
        b_next.mag  = {a_item.mag[31:0], 48'd0};
        b_vtop_next = a_v[31:16];
      end
      3'd4: begin
        b_next.mag  = {a_item.mag[15:0], 64'd0};
        b_vtop_next = a_v[15:0];
      end
      default: begin
        b_next.mag  = '0;
        b_vtop_next = '0;
      end
    endcase
  end

  // ---- fine count within the first chunk that holds a non-sign bit ----
  logic       b_hb;
  logic [7:0] b_byte;
  logic [3:0] c_f_next;
  logic       c_zero_next;

  always_comb begin
    b_hb   = (b_vtop[15:8] == 8'd0);
    b_byte = b_hb ? b_vtop[7:0] : b_vtop[15:8];
    if (!b_item.left || b_vtop == '0) c_f_next = 4'd0;
    else                              c_f_next = {b_hb, lz8(b_byte)};
    // With normalization on, a positive word with no set bit at all packs to zero before rounding.
    c_zero_next = b_item.left && !b_item.neg && (b_c == 3'd5);
  end

  // ---- fine shift, round request clear and exponent adjust ----
  logic [SHIFT_W-1:0] c_s;
  logic [HALF_W-1:0]  c_mask;
  logic               c_moved;
  item_t              d_next;

  always_comb begin
    c_s     = {c_c, 4'd0} + SHIFT_W'(c_f);
    // Bits of the old extension word that end up in the accumulator.
    c_mask  = ~({HALF_W{1'b1}} >> c_s);
    c_moved = (c_lo & c_mask) != '0;
    d_next      = c_item;
    d_next.mag  = c_item.mag << c_f;
    d_next.ex   = c_item.ex - EXP_W'(c_s);
    d_next.rnd  = c_item.rnd && !c_moved;
  end

  // ---- range checks, rounding and packing ----
  logic [17:0]       d_ml;
  logic [23:0]       d_mr;
  logic [XEXP_W-1:0] d_exf;
  logic              d_trap;
  logic              d_clear;
  logic [95:0]       e_words_next;
  logic              e_trap_next;

  always_comb begin
    d_ml   = {d_item.top2, d_item.mag[79:64]};
    d_mr   = d_item.mag[63:40] | {23'd0, d_item.rnd && !rounding_off};
    d_exf  = d_item.ex[7] ? '0 : d_item.ex[6:0];
    d_trap = d_item.ex[7] && !overflow_trap_off;
    d_clear = d_zero || d_item.ex[15] ||
              (d_ml == '0 && d_mr == '0 && !normalize_off);
    if (d_clear) begin
      e_words_next = '0;
      e_trap_next  = 1'b0;
    end else begin
      e_words_next = {d_item.mag[23:0],
                      d_item.xexp, 1'b0, d_item.mag[39:24],
                      d_mr,
                      d_exf, d_ml[16:0]};
      e_trap_next  = d_trap;
    end
  end

  assign m_tvalid = e_valid;
  assign m_tdata  = {7'd0, e_trap, e_words};

  always_ff @(posedge clk) begin
    if (rst) begin
      normalize_off     <= 1'b0;
      rounding_off      <= 1'b0;
      overflow_trap_off <= 1'b0;
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
      d_valid <= 1'b0;
      e_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_NORMALIZE_OFF:     normalize_off     <= cfg_data;
          CFG_ROUNDING_OFF:      rounding_off      <= cfg_data;
          CFG_OVERFLOW_TRAP_OFF: overflow_trap_off <= cfg_data;
          default: ;
        endcase
      end
      if (a_ready) a_valid <= s_tvalid;
      if (b_ready) b_valid <= a_valid;
      if (c_ready) c_valid <= b_valid;
      if (d_ready) d_valid <= c_valid;
      if (e_ready) e_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready) a_item <= a_next;
    if (b_ready) begin
      b_item     <= b_next;
      b_c        <= b_c_next;
      b_vtop     <= b_vtop_next;
      b_lo       <= a_item.mag[HALF_W-1:0];
    end
    if (c_ready) begin
      c_item <= b_item;
      c_c    <= b_c;
      c_f    <= c_f_next;
      c_lo   <= b_lo;
      c_zero <= c_zero_next;
    end
    if (d_ready) begin
      d_item <= d_next;
      d_zero <= c_zero;
    end
    if (e_ready) begin
      e_words <= e_words_next;
      e_trap  <= e_trap_next;
    end
  end

endmodule

// ===== test/tb_float_result_normalize_round_top.sv =====
// Testbench for float_result_normalize_round_top: directed corner words, then random
// traffic under every register setting. Depends on fnr_pkg and the top-level RTL only.
`timescale 1ns / 100ps

module tb_float_result_normalize_round_top;
  import fnr_pkg::*;

  // Input word, last declared field in the lowest bits.
  typedef struct packed {
    logic        round_request;
    logic [6:0]  ext_exponent;
    logic [23:0] ext_mant_low;
    logic [15:0] ext_mant_high;
    logic [15:0] acc_exponent;
    logic [23:0] acc_mant_low;
    logic [17:0] acc_mant_high;
  } norm_in_t;

  // Packed result word, last declared field in the lowest bits.
  typedef struct packed {
    logic        overflow_trap;
    logic [23:0] ext_word_low;
    logic [23:0] ext_word_high;
    logic [23:0] acc_word_low;
    logic [23:0] acc_word_high;
  } norm_out_t;

  localparam int IN_BITS  = $bits(norm_in_t);
  localparam int OUT_BITS = $bits(norm_out_t);

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic                  cfg_data = 1'b0;

  // Our copy of the three control bits.
  logic      norm_off  = 1'b0;
  logic      round_off = 1'b0;
  logic      trap_off  = 1'b0;

  norm_out_t packed_words_due[$];
  int        mismatch_count = 0;
  int        send_idle_pct  = 0;
  int        recv_idle_pct  = 0;

  float_result_normalize_round_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("tb_float_result_normalize_round_top: done, errors");
    $finish;
  end

  // Normalizes one word the way the block should and packs the result.
  function automatic norm_out_t normalize_and_pack(input norm_in_t w);
    norm_out_t   r;
    logic [17:0] ml;
    logic [23:0] mr;
    logic [15:0] ex;
    logic [15:0] xml;
    logic [23:0] xmr;
    logic [79:0] mag;
    logic        rnd;
    logic        trap;
    logic        neg;
    logic        in_run;
    logic        moved;
    int          lead;
    int          keep;
    r    = '0;
    ml   = w.acc_mant_high;
    mr   = w.acc_mant_low;
    ex   = w.acc_exponent;
    xml  = w.ext_mant_high;
    xmr  = w.ext_mant_low;
    rnd  = w.round_request;
    trap = 1'b0;
    if (ml[17:16] == 2'b01 || ml[17:16] == 2'b10) begin
      // Mantissa overflow: the bit that drops out of acc low becomes sticky.
      rnd = rnd | mr[0];
      {ml, mr, xml, xmr} = {ml, mr, xml, xmr} >> 1;
      ex = ex + 16'd1;
    end else if (!norm_off) begin
      neg = (ml[17:16] == 2'b11);
      if (ml[15] == neg) begin
        mag    = {ml[15:0], mr, xml, xmr};
        lead   = 0;
        in_run = 1'b1;
        for (int k = 79; k >= 0; k--) begin
          if (in_run && mag[k] == neg) begin
            lead++;
          end else begin
            in_run = 1'b0;
          end
        end
        if (!neg && lead == 80) return '0;
        // Any nonzero extension bit that climbs into acc cancels rounding.
        keep  = (lead >= 40) ? 0 : 40 - lead;
        moved = (mag[39:0] >> keep) != 40'd0;
        mag   = mag << lead;
        ml    = {neg ? 2'b11 : 2'b00, mag[79:64]};
        {mr, xml, xmr} = mag[63:0];
        ex    = ex - 16'(lead);
        if (moved) rnd = 1'b0;
      end
    end
    if (ex[15]) return '0;
    if (ex[7]) begin
      ex   = '0;
      trap = !trap_off;
    end
    if (!round_off && rnd) mr[0] = 1'b1;
    if (ml == 18'd0 && mr == 24'd0 && !norm_off) return '0;
    r.acc_word_high = {ex[6:0], ml[16:0]};
    r.acc_word_low  = mr;
    r.ext_word_high = {w.ext_exponent, 1'b0, xml};
    r.ext_word_low  = xmr;
    r.overflow_trap = trap;
    return r;
  endfunction

  function automatic norm_in_t word_of(input logic [17:0] ml, input logic [23:0] mr,
                                       input logic [15:0] ex, input logic [15:0] xml,
                                       input logic [23:0] xmr, input logic [6:0] xexp,
                                       input logic rnd);
    norm_in_t w;
    w.acc_mant_high = ml;
    w.acc_mant_low  = mr;
    w.acc_exponent  = ex;
    w.ext_mant_high = xml;
    w.ext_mant_low  = xmr;
    w.ext_exponent  = xexp;
    w.round_request = rnd;
    return w;
  endfunction

  // Mostly words with a chosen run of leading sign bits, so every shift count shows up.
  function automatic norm_in_t random_word();
    norm_in_t    w;
    logic [95:0] raw;
    logic [79:0] mag;
    logic [1:0]  sgn;
    logic [15:0] ex;
    int          run;
    raw = {$urandom, $urandom, $urandom};
    mag = raw[79:0];
    sgn = 2'($urandom_range(3));
    if ($urandom_range(9) < 7) begin
      if ($urandom_range(3) == 0) mag[39:0] = '0;
      run = $urandom_range(80);
      for (int i = 0; i < run; i++) mag[79 - i] = (sgn == 2'b11);
      if (run < 80) mag[79 - run] = (sgn != 2'b11);
    end
    case ($urandom_range(4))
      0: ex = 16'($urandom);
      1: ex = 16'($urandom_range(90));
      2: ex = 16'h0070 + 16'($urandom_range(31));
      3: ex = 16'hff80 + 16'($urandom_range(127));
      default: ex = 16'($urandom_range(127));
    endcase
    w = word_of({sgn, mag[79:64]}, mag[63:40], ex, mag[39:24], mag[23:0],
                7'($urandom_range(127)), 1'($urandom_range(1)));
    return w;
  endfunction

  task automatic flag_mismatch(input string what, input logic [OUT_DATA_W-1:0] got,
                               input logic [OUT_DATA_W-1:0] want);
    if (mismatch_count < 100) begin
      $display("%0t: %s mismatch, got %h, expected %h", $time, what, got, want);
    end
    mismatch_count++;
  endtask

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic send_word(input norm_in_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = {{(IN_DATA_W - IN_BITS){1'b0}}, w};
    do @(posedge clk); while (!s_tready);
    packed_words_due.push_back(normalize_and_pack(w));
    @(negedge clk);
  endtask

  task automatic wait_until_drained();
    s_tvalid = 1'b0;
    while (packed_words_due.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // Leaves cfg_valid high so that back-to-back writes do not toggle it.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_NORMALIZE_OFF:     norm_off  = val;
      CFG_ROUNDING_OFF:      round_off = val;
      CFG_OVERFLOW_TRAP_OFF: trap_off  = val;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic apply_settings(input logic n_off, input logic r_off, input logic t_off);
    wait_until_drained();
    write_reg(CFG_NORMALIZE_OFF, n_off);
    write_reg(CFG_ROUNDING_OFF, r_off);
    write_reg(CFG_OVERFLOW_TRAP_OFF, t_off);
    cfg_valid = 1'b0;
  endtask

  task automatic test_special_cases();
    send_idle_pct = 30;
    recv_idle_pct = 30;
    apply_settings(1'b0, 1'b0, 1'b0);
    send_word(word_of(18'h00000, 24'h000000, 16'h0005, 16'h0000, 24'h000000, 7'h7f, 1'b1));
    send_word(word_of(18'h00000, 24'h000000, 16'h0000, 16'h0000, 24'h000000, 7'h00, 1'b0));
    send_word(word_of(18'h08000, 24'h000000, 16'h0010, 16'h0000, 24'h000000, 7'h2a, 1'b1));
    send_word(word_of(18'h10001, 24'h000001, 16'h0020, 16'hffff, 24'hffffff, 7'h00, 1'b0));
    // Right shift with the exponent wrapping from all ones to zero.
    send_word(word_of(18'h2ffff, 24'h123456, 16'hffff, 16'h0001, 24'h000001, 7'h7f, 1'b0));
    send_word(word_of(18'h10000, 24'h000000, 16'h007f, 16'h0000, 24'h000000, 7'h01, 1'b0));
    send_word(word_of(18'h0ffff, 24'hffffff, 16'h0080, 16'h1234, 24'h654321, 7'h11, 1'b1));
    send_word(word_of(18'h08000, 24'h000000, 16'h8000, 16'h0000, 24'h000000, 7'h22, 1'b0));
    send_word(word_of(18'h00001, 24'h000000, 16'h0003, 16'h0000, 24'h000000, 7'h33, 1'b0));
    // All-ones negative magnitude shifts all the way out.
    send_word(word_of(18'h3ffff, 24'hffffff, 16'h0060, 16'hffff, 24'hffffff, 7'h7f, 1'b1));
    send_word(word_of(18'h3ffff, 24'hffffff, 16'hffff, 16'hffff, 24'hffffff, 7'h7f, 1'b1));
    send_word(word_of(18'h37fff, 24'h000000, 16'h0040, 16'h0000, 24'h000000, 7'h00, 1'b1));
    send_word(word_of(18'h3ffff, 24'h7fffff, 16'h0050, 16'h0000, 24'h000000, 7'h00, 1'b1));
    send_word(word_of(18'h00000, 24'h800000, 16'h0050, 16'h0000, 24'h000000, 7'h00, 1'b1));
    send_word(word_of(18'h00000, 24'h000000, 16'h0060, 16'h8000, 24'h000001, 7'h00, 1'b1));
    send_word(word_of(18'h00000, 24'h000000, 16'h0060, 16'h0000, 24'h800000, 7'h00, 1'b1));
    send_word(word_of(18'h00000, 24'h000000, 16'h0060, 16'h0000, 24'h000001, 7'h00, 1'b0));
    apply_settings(1'b1, 1'b1, 1'b1);
    send_word(word_of(18'h00000, 24'h000000, 16'h0033, 16'h0000, 24'h000000, 7'h55, 1'b1));
    send_word(word_of(18'h00001, 24'h000000, 16'h0010, 16'h0000, 24'h000000, 7'h00, 1'b1));
    send_word(word_of(18'h08000, 24'h000000, 16'h0080, 16'h0000, 24'h000000, 7'h00, 1'b0));
    send_word(word_of(18'h20000, 24'h000001, 16'h0010, 16'h0000, 24'h000000, 7'h00, 1'b1));
    apply_settings(1'b1, 1'b0, 1'b0);
    send_word(word_of(18'h00000, 24'h000000, 16'h0044, 16'h0000, 24'h000000, 7'h00, 1'b1));
  endtask

  // Random words under each of the eight register settings with one idle profile.
  task automatic test_random_traffic(input int snd_pct, input int rcv_pct);
    logic [2:0] sel;
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    for (int c = 0; c < 8; c++) begin
      sel = 3'(c);
      apply_settings(sel[0], sel[1], sel[2]);
      for (int i = 0; i < 70; i++) send_word(random_word());
    end
  endtask

  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    norm_out_t got;
    norm_out_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[OUT_BITS-1:0];
      if (packed_words_due.size() == 0) begin
        flag_mismatch("unexpected word", m_tdata, '0);
      end else begin
        want = packed_words_due.pop_front();
        if (got.acc_word_high !== want.acc_word_high)
          flag_mismatch("acc_word_high", OUT_DATA_W'(got.acc_word_high),
                        OUT_DATA_W'(want.acc_word_high));
        if (got.acc_word_low !== want.acc_word_low)
          flag_mismatch("acc_word_low", OUT_DATA_W'(got.acc_word_low),
                        OUT_DATA_W'(want.acc_word_low));
        if (got.ext_word_high !== want.ext_word_high)
          flag_mismatch("ext_word_high", OUT_DATA_W'(got.ext_word_high),
                        OUT_DATA_W'(want.ext_word_high));
        if (got.ext_word_low !== want.ext_word_low)
          flag_mismatch("ext_word_low", OUT_DATA_W'(got.ext_word_low),
                        OUT_DATA_W'(want.ext_word_low));
        if (got.overflow_trap !== want.overflow_trap)
          flag_mismatch("overflow_trap", OUT_DATA_W'(got.overflow_trap),
                        OUT_DATA_W'(want.overflow_trap));
        if (m_tdata[OUT_DATA_W-1:OUT_BITS] !== '0)
          flag_mismatch("zero fill", OUT_DATA_W'(m_tdata[OUT_DATA_W-1:OUT_BITS]), '0);
      end
    end
  end

  initial begin
    repeat (10) @(negedge clk);
    rst = 1'b0;
    test_special_cases();
    test_random_traffic(18, 65);
    test_random_traffic(65, 18);
    test_random_traffic(0, 0);
    wait_until_drained();
    repeat (10) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("tb_float_result_normalize_round_top: done, clean");
    end else begin
      $display("tb_float_result_normalize_round_top: done, errors");
    end
    $finish;
  end

endmodule
